// ----- rtl/pphc_pkg.sv -----
// Shared types and constants for the positional pattern hit counter.
// No dependencies; imported by pphc_match and the top level.
package pphc_pkg;

    // Request type codes
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_SCAN = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_NOT_LOADED = 2'd2;
    localparam logic [1:0] ST_SKIPPED    = 2'd3;

    // Match modes
    localparam logic [1:0] MODE_WHOLE = 2'd0;
    localparam logic [1:0] MODE_POS1  = 2'd1;
    localparam logic [1:0] MODE_POS2  = 2'd2;
    localparam logic [1:0] MODE_POS3  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_MATCH_MODE = 3'd0;
    localparam logic [2:0] REG_ITEM_POS1  = 3'd1;
    localparam logic [2:0] REG_ITEM_POS2  = 3'd2;
    localparam logic [2:0] REG_ITEM_POS3  = 3'd3;
    localparam logic [2:0] REG_PAT_POS1   = 3'd4;
    localparam logic [2:0] REG_PAT_POS2   = 3'd5;
    localparam logic [2:0] REG_PAT_POS3   = 3'd6;
    localparam logic [2:0] REG_PAT_LEN    = 3'd7;

    // Header words that are never scanned, packed byte 0 in the low bits
    localparam logic [63:0] WORD_DATELINE = 64'h454E_494C_4554_4144;
    localparam logic [63:0] WORD_HEADLINE = 64'h454E_494C_4441_4548;
    localparam logic [7:0]  CHAR_SPACE    = 8'h20;

    localparam logic [3:0] PAT_LEN_RESET = 4'd8;
    localparam int unsigned MATCHED_W    = 11;

    typedef struct packed {
        logic [1:0] match_mode;
        logic [2:0] item_pos1;
        logic [2:0] item_pos2;
        logic [2:0] item_pos3;
        logic [2:0] pat_pos1;
        logic [2:0] pat_pos2;
        logic [2:0] pat_pos3;
        logic [3:0] pat_len;
    } t_cfg;

endpackage

// ----- rtl/pphc_match.sv -----
// Compare unit: decides whether one stored pattern matches the scanned word.
// Depends on pphc_pkg (t_cfg, mode codes).
module pphc_match #(
    parameter int MAX_LEN = 8
) (
    input  logic [8*MAX_LEN-1:0] i_word,
    input  logic [8*MAX_LEN-1:0] i_pattern,
    input  pphc_pkg::t_cfg       i_cfg,
    output logic                 o_hit
);
    import pphc_pkg::*;

    logic [63:0] word_x;
    logic [63:0] pat_x;
    logic [7:0]  w1, w2, w3, p1, p2, p3;
    logic        whole_hit;

    // Letter at a chosen position; positions past MAX_LEN read as zero
    function automatic logic [7:0] letter_at(input logic [63:0] v, input logic [2:0] p);
        logic [7:0] b;
        b = v[{p, 3'b000} +: 8];
        return (32'(p) < MAX_LEN) ? b : 8'd0;
    endfunction

    assign word_x = 64'(i_word);
    assign pat_x  = 64'(i_pattern);

    assign w1 = letter_at(word_x, i_cfg.item_pos1);
    assign w2 = letter_at(word_x, i_cfg.item_pos2);
    assign w3 = letter_at(word_x, i_cfg.item_pos3);
    assign p1 = letter_at(pat_x, i_cfg.pat_pos1);
    assign p2 = letter_at(pat_x, i_cfg.pat_pos2);
    assign p3 = letter_at(pat_x, i_cfg.pat_pos3);

    // Whole-prefix compare over the first pat_len letters
    always_comb begin
        whole_hit = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if ((4'(i) < i_cfg.pat_len) && (word_x[8*i +: 8] != pat_x[8*i +: 8])) begin
                whole_hit = 1'b0;
            end
        end
    end

    always_comb begin
        unique case (i_cfg.match_mode)
            MODE_WHOLE: o_hit = whole_hit;
            MODE_POS1:  o_hit = (w1 == p1);
            MODE_POS2:  o_hit = (w1 == p1) && (w2 == p2);
            MODE_POS3:  o_hit = (w1 == p1) && (w2 == p2) && (w3 == p3);
            default:    o_hit = 1'b0;
        endcase
    end

endmodule

// ----- rtl/positional_pattern_hit_counter_unit.sv -----
// Positional pattern hit counter: pattern/counter tables, sequencer, output register.
// Depends on pphc_pkg and pphc_match.
// Load, unknown request, skipped scan and read of an unloaded entry go from
// idle straight to finish; a read of a loaded entry passes through the read
// state; a scan walks the loaded entries, one table entry compared per cycle
// through the single compare unit and the counter read-modify-write port.
// One item at a time; a finished result may wait in the output register.
// Reset (synchronous, active low) clears config, entry count and control;
// counters need no clearing pass, each is zeroed when its entry is loaded.
module positional_pattern_hit_counter_unit #(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_LEN     = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_addr,
    input  logic [3:0]  i_cfg_wdata,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [63:0] i_word_bytes,
    input  logic [6:0]  i_word_len,
    input  logic [9:0]  i_entry_index,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [63:0] o_pattern_bytes,
    output logic [31:0] o_hit_count,
    output logic [10:0] o_matched
);
    import pphc_pkg::*;

    localparam int PW = 8 * MAX_LEN;
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (CW > 10) ? CW : 10;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_READ   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    // Tables
    logic [PW-1:0]          mem_pat [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] mem_cnt [TABLE_DEPTH];

    t_cfg                   r_cfg;
    logic [1:0]             r_state;
    logic [CW-1:0]          r_entry_count;
    logic [CW-1:0]          r_idx;
    logic [AW-1:0]          r_wb_addr;
    logic                   r_pipe_vld;
    logic [PW-1:0]          r_word;
    logic [PW-1:0]          r_pat_q;
    logic [COUNT_WIDTH-1:0] r_cnt_q;

    logic [1:0]             r_res_status;
    logic [PW-1:0]          r_res_pat;
    logic [COUNT_WIDTH-1:0] r_res_cnt;
    logic [MATCHED_W-1:0]   r_res_matched;

    logic                   r_out_valid;
    logic [1:0]             r_status;
    logic [PW-1:0]          r_pattern;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [MATCHED_W-1:0]   r_matched;

    logic                   accept;
    logic                   table_full;
    logic                   skip_word;
    logic                   space_hit;
    logic                   issue;
    logic                   hit;
    logic                   load_we;
    logic                   cnt_we;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic [COUNT_WIDTH-1:0] cnt_wdata;
    logic [XW-1:0]          idx_x;
    logic                   idx_loaded;
    logic                   out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign table_full = (r_entry_count == CW'(TABLE_DEPTH));
    assign idx_x      = XW'(i_entry_index);
    assign idx_loaded = idx_x < XW'(r_entry_count);
    assign issue      = (r_state == S_SCAN) && (r_idx < r_entry_count);

    // Space in the checked span of the incoming word
    always_comb begin
        logic in_span;
        space_hit = 1'b0;
        for (int p = 0; p < 8; p++) begin
            unique case (r_cfg.match_mode)
                MODE_WHOLE: in_span = (4'(p) < r_cfg.pat_len);
                MODE_POS1:  in_span = (3'(p) == r_cfg.item_pos1);
                MODE_POS2:  in_span = (3'(p) >= r_cfg.item_pos1) &&
                                      (3'(p) <= r_cfg.item_pos2);
                MODE_POS3:  in_span = (3'(p) >= r_cfg.item_pos1) &&
                                      (3'(p) <= r_cfg.item_pos3);
                default:    in_span = 1'b0;
            endcase
            if (in_span && (p < MAX_LEN) && (i_word_bytes[8*p +: 8] == CHAR_SPACE)) begin
                space_hit = 1'b1;
            end
        end
    end

    assign skip_word = ((i_word_len == 7'd8) &&
                        ((i_word_bytes == WORD_DATELINE) || (i_word_bytes == WORD_HEADLINE)))
                       || space_hit;

    // Shared compare unit
    pphc_match #(
        .MAX_LEN (MAX_LEN)
    ) u_match (
        .i_word    (r_word),
        .i_pattern (r_pat_q),
        .i_cfg     (r_cfg),
        .o_hit     (hit)
    );

    // Table port control
    assign load_we   = accept && (i_req_type == REQ_LOAD) && !table_full;
    assign cnt_we    = load_we ||
                       ((r_state == S_SCAN) && r_pipe_vld && hit && !(&r_cnt_q));
    assign wr_addr   = load_we ? r_entry_count[AW-1:0] : r_wb_addr;
    assign cnt_wdata = load_we ? '0 : r_cnt_q + COUNT_WIDTH'(1);
    assign rd_addr   = (r_state == S_SCAN) ? r_idx[AW-1:0] : idx_x[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (load_we) begin
            mem_pat[wr_addr] <= i_word_bytes[PW-1:0];
        end
        r_pat_q <= mem_pat[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            mem_cnt[wr_addr] <= cnt_wdata;
        end
        r_cnt_q <= mem_cnt[rd_addr];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{match_mode: MODE_WHOLE, item_pos1: 3'd0, item_pos2: 3'd0,
                       item_pos3: 3'd0, pat_pos1: 3'd0, pat_pos2: 3'd0,
                       pat_pos3: 3'd0, pat_len: PAT_LEN_RESET};
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_MATCH_MODE: r_cfg.match_mode <= i_cfg_wdata[1:0];
                REG_ITEM_POS1:  r_cfg.item_pos1  <= i_cfg_wdata[2:0];
                REG_ITEM_POS2:  r_cfg.item_pos2  <= i_cfg_wdata[2:0];
                REG_ITEM_POS3:  r_cfg.item_pos3  <= i_cfg_wdata[2:0];
                REG_PAT_POS1:   r_cfg.pat_pos1   <= i_cfg_wdata[2:0];
                REG_PAT_POS2:   r_cfg.pat_pos2   <= i_cfg_wdata[2:0];
                REG_PAT_POS3:   r_cfg.pat_pos3   <= i_cfg_wdata[2:0];
                REG_PAT_LEN:    r_cfg.pat_len    <= i_cfg_wdata;
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    // Sequencer control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_entry_count <= '0;
            r_pipe_vld    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // a new result replaces one taken at the same edge
            if ((r_state == S_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_pipe_vld <= 1'b0;
                    if (accept) begin
                        priority if (i_req_type == REQ_SCAN && !skip_word) begin
                            r_state <= S_SCAN;
                        end else if (i_req_type == REQ_READ && idx_loaded) begin
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_FINISH;
                        end
                        if (load_we) begin
                            r_entry_count <= r_entry_count + CW'(1);
                        end
                    end
                end
                S_SCAN: begin
                    r_pipe_vld <= issue;
                    if (!issue && !r_pipe_vld) begin
                        r_state <= S_FINISH;
                    end
                end
                S_READ: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath: scan walk, result assembly, output register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word        <= i_word_bytes[PW-1:0];
            r_idx         <= '0;
            r_res_pat     <= '0;
            r_res_cnt     <= '0;
            r_res_matched <= '0;
            unique case (i_req_type)
                REQ_LOAD: r_res_status <= table_full ? ST_FULL : ST_OK;
                REQ_SCAN: r_res_status <= skip_word ? ST_SKIPPED : ST_OK;
                REQ_READ: r_res_status <= idx_loaded ? ST_OK : ST_NOT_LOADED;
                default:  r_res_status <= ST_OK;
            endcase
        end
        if (issue) begin
            r_idx     <= r_idx + CW'(1);
            r_wb_addr <= r_idx[AW-1:0];
        end
        if ((r_state == S_SCAN) && r_pipe_vld && hit && !(&r_res_matched)) begin
            r_res_matched <= r_res_matched + MATCHED_W'(1);
        end
        if (r_state == S_READ) begin
            r_res_pat <= r_pat_q;
            r_res_cnt <= r_cnt_q;
        end
        if ((r_state == S_FINISH) && out_free) begin
            r_status  <= r_res_status;
            r_pattern <= r_res_pat;
            r_count   <= r_res_cnt;
            r_matched <= r_res_matched;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_pattern_bytes = 64'(r_pattern);
    assign o_hit_count     = 32'(r_count);
    assign o_matched       = r_matched;

endmodule
